// ----- design/pfp_pkg.sv -----
// ---------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants of the parameter frame parser.
// ---------------------------------------------------------------------------
package pfp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'hAA;
  localparam logic [7:0] BCAST_ADDR = 8'hFF;
  localparam logic [7:0] FN_READ    = 8'hE1;
  localparam logic [7:0] FN_WRITE   = 8'hE2;
  localparam logic [15:0] TYPE_ID   = 16'd1;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_TYPE = 4'd1;

  localparam logic [7:0] DEV_ADDR_RST = 8'h05;
  localparam logic [7:0] DEV_TYPE_RST = 8'h05;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } pfp_kind_e;

  // frame completed with good checks and a known function
  typedef struct packed {
    logic        vld;
    pfp_kind_e   kind;
    logic [15:0] id;
    logic [31:0] value;
    logic [7:0]  func;
    logic [7:0]  sum;
    logic [7:0]  add;
  } pfp_evt_t;

endpackage

// ----- design/pfp_if.sv -----
// ---------------------------------------------------------------------------
// pfp_if
// Channel interfaces: frame bytes in, replies out, configuration writes.
// ---------------------------------------------------------------------------
interface pfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface pfp_reply_if;
  logic               valid;
  logic               ready;
  logic               reply_kind;
  logic [15:0]        param_id;
  logic signed [31:0] param_value;
  logic [7:0]         ack_function;
  logic [7:0]         ack_sum;
  logic [7:0]         ack_add;

  modport source (output valid, output reply_kind, output param_id, output param_value,
                  output ack_function, output ack_sum, output ack_add, input ready);
  modport sink   (input valid, input reply_kind, input param_id, input param_value,
                  input ack_function, input ack_sum, input ack_add, output ready);
endinterface

interface pfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pfp_pkg::CFG_IDX_W-1:0]  index;
  logic [pfp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/pfp_ram.sv -----
// ---------------------------------------------------------------------------
// pfp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pfp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 6
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pfp_rx.sv -----
// ---------------------------------------------------------------------------
// pfp_rx
// Frame tracker: position, address check, running sum and add checks,
// capture of the first six data bytes. Flags a completed good frame.
// ---------------------------------------------------------------------------
module pfp_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        data_i,
  input  logic              start_i,
  input  logic [7:0]        dev_addr_i,
  output pfp_pkg::pfp_evt_t evt_o
);

  logic [8:0]  pos_q, pos_d, pos_e;
  logic        live_q, live_d, live_e;
  logic [7:0]  func_q, func_d, func_e;
  logic [7:0]  len_q, len_d, len_e;
  logic [7:0]  rsum_q, rsum_d, rsum_e;
  logic [7:0]  radd_q, radd_d, radd_e;
  logic [7:0]  csum_q, csum_d, csum_e;
  logic [47:0] head_q, head_d, head_e;
  logic [8:0]  end_pos;
  logic [8:0]  hofs;
  logic [7:0]  sum_nx;

  always_comb begin
    if (start_i) begin
      pos_e  = '0;
      live_e = 1'b1;
      func_e = '0;
      len_e  = '0;
      rsum_e = '0;
      radd_e = '0;
      csum_e = '0;
      head_e = '0;
    end else begin
      pos_e  = pos_q;
      live_e = live_q;
      func_e = func_q;
      len_e  = len_q;
      rsum_e = rsum_q;
      radd_e = radd_q;
      csum_e = csum_q;
      head_e = head_q;
    end
  end

  assign end_pos = {1'b0, len_e} + 9'd4;
  assign hofs    = pos_e - 9'd4;
  assign sum_nx  = rsum_e + data_i;

  always_comb begin
    pos_d  = pos_e;
    live_d = live_e;
    func_d = func_e;
    len_d  = len_e;
    rsum_d = rsum_e;
    radd_d = radd_e;
    csum_d = csum_e;
    head_d = head_e;
    evt_o  = '0;
    evt_o.id    = head_e[15:0];
    evt_o.value = head_e[47:16];
    evt_o.func  = func_e;
    evt_o.sum   = csum_e;
    evt_o.add   = data_i;
    evt_o.kind  = (func_e == pfp_pkg::FN_WRITE) ? pfp_pkg::KIND_WRITE : pfp_pkg::KIND_READ;
    if (live_e) begin
      if (pos_e < 9'd4 || pos_e < end_pos) begin
        if (pos_e == 9'd0 && data_i != pfp_pkg::HDR_BYTE) begin
          live_d = 1'b0;
        end else if (pos_e == 9'd1 && data_i != pfp_pkg::BCAST_ADDR
                     && data_i != dev_addr_i) begin
          live_d = 1'b0;
        end else begin
          if (pos_e == 9'd2) func_d = data_i;
          if (pos_e == 9'd3) len_d = data_i;
          if (pos_e >= 9'd4 && hofs < 9'd6) begin
            head_d[8*hofs[2:0] +: 8] = data_i;
          end
          rsum_d = sum_nx;
          radd_d = radd_e + sum_nx;
          pos_d  = pos_e + 9'd1;
        end
      end else if (pos_e == end_pos) begin
        if (data_i != rsum_e) begin
          live_d = 1'b0;
        end else begin
          csum_d = data_i;
          pos_d  = pos_e + 9'd1;
        end
      end else begin
        live_d = 1'b0;
        evt_o.vld = (data_i == radd_e)
                    && (func_e == pfp_pkg::FN_READ || func_e == pfp_pkg::FN_WRITE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      live_q <= 1'b0;
      func_q <= '0;
      len_q  <= '0;
      rsum_q <= '0;
      radd_q <= '0;
      csum_q <= '0;
      head_q <= '0;
    end else if (acc_i) begin
      pos_q  <= pos_d;
      live_q <= live_d;
      func_q <= func_d;
      len_q  <= len_d;
      rsum_q <= rsum_d;
      radd_q <= radd_d;
      csum_q <= csum_d;
      head_q <= head_d;
    end
  end

endmodule

// ----- design/param_frame_parser.sv -----
// ---------------------------------------------------------------------------
// param_frame_parser
// Sum/add checked parameter frame parser with a RAM-backed parameter store.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                          request
//  byte_i    in   data_byte, frame_start                           one frame byte
//  reply_o   out  reply_kind, param_id, param_value, ack_*         one reply
//  cfg_i     in   index, data                                      register write
//
//  One byte per cycle. After the add check byte a reply passes the
//  parameter RAM read stage, then the output register. Reset clears
//  the frame state, the store valid bits and the stage valid flags.
//  A stalled reply holds the RAM stage; bytes are then held off until the
//  output register frees. Writes land in the RAM on the add check byte.
// ---------------------------------------------------------------------------
module param_frame_parser #(
  parameter int unsigned NUM_PARAMS     = 6,
  parameter int unsigned FIRST_PARAM_ID = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfp_byte_if.sink      byte_i,
  pfp_reply_if.source   reply_o,
  pfp_cfg_if.sink       cfg_i
);

  localparam int unsigned AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  logic [7:0] dev_addr_q, dev_type_q;

  pfp_pkg::pfp_evt_t evt;
  logic        in_acc;
  logic [16:0] diff;
  logic        hit;
  logic [AW-1:0] slot;
  logic        ram_we, ram_re;
  logic [31:0] ram_rdata;
  logic [NUM_PARAMS-1:0] wrt_q;

  logic        s1_vld_q;
  pfp_pkg::pfp_kind_e s1_kind_q;
  logic [15:0] s1_id_q;
  logic        s1_hit_q, s1_wrt_q;
  logic [7:0]  s1_func_q, s1_sum_q, s1_add_q;
  logic        s1_adv;

  logic        out_vld_q;
  logic        out_kind_q;
  logic [15:0] out_id_q;
  logic [31:0] out_val_q, out_val_d;
  logic [7:0]  out_func_q, out_sum_q, out_add_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= pfp_pkg::DEV_ADDR_RST;
      dev_type_q <= pfp_pkg::DEV_TYPE_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == pfp_pkg::CFG_DEV_ADDR) dev_addr_q <= cfg_i.data;
      if (cfg_i.index == pfp_pkg::CFG_DEV_TYPE) dev_type_q <= cfg_i.data;
    end
  end

  // frame tracking
  assign s1_adv       = s1_vld_q && (!out_vld_q || reply_o.ready);
  assign byte_i.ready = !s1_vld_q || s1_adv;
  assign in_acc       = byte_i.valid && byte_i.ready;

  pfp_rx u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .data_i     (byte_i.data_byte),
    .start_i    (byte_i.frame_start),
    .dev_addr_i (dev_addr_q),
    .evt_o      (evt)
  );

  // parameter slot lookup
  assign diff = {1'b0, evt.id} - 17'(FIRST_PARAM_ID);
  assign hit  = !diff[16] && (diff < 17'(NUM_PARAMS));
  assign slot = diff[AW-1:0];

  assign ram_we = in_acc && evt.vld && (evt.kind == pfp_pkg::KIND_WRITE) && hit;
  assign ram_re = in_acc && evt.vld && (evt.kind == pfp_pkg::KIND_READ) && hit;

  pfp_ram #(
    .WIDTH (32),
    .DEPTH (NUM_PARAMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (evt.value),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // never-written slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrt_q <= '0;
    end else if (ram_we) begin
      wrt_q[slot] <= 1'b1;
    end
  end

  // RAM read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= evt.vld;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && evt.vld) begin
      s1_kind_q <= evt.kind;
      s1_id_q   <= evt.id;
      s1_hit_q  <= hit;
      s1_wrt_q  <= wrt_q[slot];
      s1_func_q <= evt.func;
      s1_sum_q  <= evt.sum;
      s1_add_q  <= evt.add;
    end
  end

  // output register
  always_comb begin
    if (s1_id_q == pfp_pkg::TYPE_ID) begin
      out_val_d = {24'd0, dev_type_q};
    end else if (s1_hit_q) begin
      out_val_d = s1_wrt_q ? ram_rdata : 32'd0;
    end else begin
      out_val_d = {16'd0, s1_id_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (reply_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_kind_q == pfp_pkg::KIND_WRITE) begin
        out_kind_q <= pfp_pkg::KIND_WRITE;
        out_id_q   <= '0;
        out_val_q  <= '0;
        out_func_q <= s1_func_q;
        out_sum_q  <= s1_sum_q;
        out_add_q  <= s1_add_q;
      end else begin
        out_kind_q <= pfp_pkg::KIND_READ;
        out_id_q   <= s1_id_q;
        out_val_q  <= out_val_d;
        out_func_q <= '0;
        out_sum_q  <= '0;
        out_add_q  <= '0;
      end
    end
  end

  assign reply_o.valid        = out_vld_q;
  assign reply_o.reply_kind   = out_kind_q;
  assign reply_o.param_id     = out_id_q;
  assign reply_o.param_value  = out_val_q;
  assign reply_o.ack_function = out_func_q;
  assign reply_o.ack_sum      = out_sum_q;
  assign reply_o.ack_add      = out_add_q;

  // checks
  a_ram_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_adv |=> s1_vld_q && $stable(s1_id_q))
    else $error("stalled RAM stage lost its request");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_adv |-> !ram_re && !ram_we)
    else $error("store accessed while RAM stage stalled");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("reply not loaded into output register");

endmodule
